/* hdl/dog_keypoint_window_test_assert.svh */
// ---------------------------------------------------------------------------
// dog_keypoint_window_test_assert.svh
// Assertion macros for the DoG keypoint window test; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef DOG_KEYPOINT_WINDOW_TEST_ASSERT_SVH
`define DOG_KEYPOINT_WINDOW_TEST_ASSERT_SVH

`ifndef SYNTHESIS

// cond true at an edge -> expr true at the same edge
`define DKWT_ASSERT_SAME(label, clock, reset_n, cond, expr) \
    label: assert property (@(posedge clock) disable iff (!reset_n) \
        (cond) |-> (expr)) else $error("dkwt: same-cycle check failed");

// cond true at an edge -> expr true at the next edge
`define DKWT_ASSERT_NEXT(label, clock, reset_n, cond, expr) \
    label: assert property (@(posedge clock) disable iff (!reset_n) \
        (cond) |=> (expr)) else $error("dkwt: next-cycle check failed");

`else

`define DKWT_ASSERT_SAME(label, clock, reset_n, cond, expr)
`define DKWT_ASSERT_NEXT(label, clock, reset_n, cond, expr)

`endif

`endif

/* hdl/dkwt_pkg.sv */
// ---------------------------------------------------------------------------
// dkwt_pkg
// Types and constants for the DoG keypoint window test.
// ---------------------------------------------------------------------------
package dkwt_pkg;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 15;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_CONTRAST = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_RATIO    = 2'd1;

    localparam int THR_WIDTH   = 15;
    localparam int RATIO_WIDTH = 8;
    localparam int RSQ_WIDTH   = 2 * (RATIO_WIDTH + 1) - 1;  // (r+1)^2 <= 65536

    localparam logic [THR_WIDTH-1:0]   THR_RESET   = 15'd218;
    localparam logic [RATIO_WIDTH-1:0] RATIO_RESET = 8'd10;
    localparam logic [RSQ_WIDTH-1:0]   RSQ_RESET   = 17'd121;

    // window taps, row by row
    localparam int NUM_TAPS  = 9;
    localparam int TAP_TL    = 0;
    localparam int TAP_TM    = 1;
    localparam int TAP_TR    = 2;
    localparam int TAP_ML    = 3;
    localparam int TAP_C     = 4;
    localparam int TAP_MR    = 5;
    localparam int TAP_BL    = 6;
    localparam int TAP_BM    = 7;
    localparam int TAP_BR    = 8;

    localparam int OUT_TDATA_WIDTH = 8;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_MAX  = 2'd1,
        KIND_MIN  = 2'd2
    } kind_t;

endpackage

/* hdl/dog_keypoint_window_test.sv */
// ---------------------------------------------------------------------------
// dog_keypoint_window_test
// Keypoint test on a 3x3 difference-of-Gaussian window: contrast,
// extremum and Hessian edge rejection, five register stages.
// ---------------------------------------------------------------------------
// One window is taken per clock unless back-pressure from m_tready holds
// the stages full. The five stages are: window differences and compares,
// the three products dxx*dyy, dxy^2 and trace^2, the determinant plus
// trace^2*r, det*(r+1)^2 as two partial products, and
// the final wide add and compare in the output register. Each stage loads
// whenever it is empty or the stage after it moves, so bubbles collapse and
// a new window is accepted even while a result waits at the output. The
// tdata word carries the nine samples, SAMPLE_WIDTH bits each, top_left in
// the lowest bits. Configuration writes are always accepted; write them
// only while no window is in flight. The edge test compares
// (A+B)^2*r < (r+1)^2*det exactly, with no rounding.
// ---------------------------------------------------------------------------
`include "dog_keypoint_window_test_assert.svh"

module dog_keypoint_window_test #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,

    // window stream
    input  logic s_tvalid,
    output logic s_tready,
    // tdata, low bit up: top_left, top_mid, top_right, mid_left, center,
    // mid_right, bot_left, bot_mid, bot_right, zero pad to whole bytes
    input  logic [((9 * SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,

    // result stream
    output logic m_tvalid,
    input  logic m_tready,
    // tdata, low bit up: is_keypoint, extremum_kind[1:0], contrast_ok,
    // edge_rejected, zero pad
    output logic [dkwt_pkg::OUT_TDATA_WIDTH-1:0] m_tdata,

    // configuration writes
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dkwt_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [dkwt_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);

    localparam int W      = SAMPLE_WIDTH;
    localparam int DW     = 2 * W + 9;          // signed determinant
    localparam int K      = W + 4;              // det split point
    localparam int RW     = 2 * W + 25;         // det*(r+1)^2
    localparam int CMP_W  = (W + 1 > dkwt_pkg::THR_WIDTH) ? W + 1 : dkwt_pkg::THR_WIDTH;

    // -----------------------------------------------------------------
    // configuration registers
    // -----------------------------------------------------------------
    logic [dkwt_pkg::THR_WIDTH-1:0]   thr_reg,   thr_next;
    logic [dkwt_pkg::RATIO_WIDTH-1:0] ratio_reg, ratio_next;
    logic [dkwt_pkg::RSQ_WIDTH-1:0]   rsq_reg,   rsq_next;   // (r+1)^2 kept ready
    logic [dkwt_pkg::RSQ_WIDTH-1:0]   ratio_inc;

    assign cfg_ready = 1'b1;
    assign ratio_inc = dkwt_pkg::RSQ_WIDTH'(cfg_data[dkwt_pkg::RATIO_WIDTH-1:0]) + 1'b1;

    always_comb
    begin
        thr_next   = thr_reg;
        ratio_next = ratio_reg;
        rsq_next   = rsq_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dkwt_pkg::CFG_IDX_CONTRAST:
                begin
                    thr_next = cfg_data[dkwt_pkg::THR_WIDTH-1:0];
                end
                dkwt_pkg::CFG_IDX_RATIO:
                begin
                    ratio_next = cfg_data[dkwt_pkg::RATIO_WIDTH-1:0];
                    rsq_next   = ratio_inc * ratio_inc;
                end
                default:
                begin
                    // unknown index: write dropped
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= dkwt_pkg::THR_RESET;
            ratio_reg <= dkwt_pkg::RATIO_RESET;
            rsq_reg   <= dkwt_pkg::RSQ_RESET;
        end
        else
        begin
            thr_reg   <= thr_next;
            ratio_reg <= ratio_next;
            rsq_reg   <= rsq_next;
        end
    end

    // -----------------------------------------------------------------
    // stage enables: a stage loads when empty or when its successor moves
    // -----------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, m_tvalid_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !m_tvalid_reg || m_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_tready = en1;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg       <= s_tvalid;
            if (en2) v2_reg       <= v1_reg;
            if (en3) v3_reg       <= v2_reg;
            if (en4) v4_reg       <= v3_reg;
            if (en5) m_tvalid_reg <= v4_reg;
        end
    end

    // -----------------------------------------------------------------
    // stage 1: differences, extremum and contrast
    // -----------------------------------------------------------------
    logic signed [W-1:0] tap [dkwt_pkg::NUM_TAPS];
    logic signed [W+1:0] ext [dkwt_pkg::NUM_TAPS];

    always_comb
    begin
        for (int i = 0; i < dkwt_pkg::NUM_TAPS; i++)
        begin
            tap[i] = $signed(s_tdata[i * W +: W]);
            ext[i] = (W + 2)'(tap[i]);
        end
    end

    logic signed [W+1:0] dxx_next, dyy_next, dxy_next;
    logic signed [W+2:0] trace;
    logic        [W+2:0] tabs_next;
    logic                is_max, is_min, c_pos;
    logic signed [W:0]   c_ext;
    logic        [W:0]   cmag;
    logic                contrast_next;
    dkwt_pkg::kind_t     kind_next;

    assign dxx_next = ext[dkwt_pkg::TAP_MR] + ext[dkwt_pkg::TAP_ML] - (ext[dkwt_pkg::TAP_C] <<< 1);
    assign dyy_next = ext[dkwt_pkg::TAP_BM] + ext[dkwt_pkg::TAP_TM] - (ext[dkwt_pkg::TAP_C] <<< 1);
    // this is 4*dxy, an integer
    assign dxy_next = ext[dkwt_pkg::TAP_BR] - ext[dkwt_pkg::TAP_BL]
                    - ext[dkwt_pkg::TAP_TR] + ext[dkwt_pkg::TAP_TL];
    assign trace     = (W + 3)'(dxx_next) + (W + 3)'(dyy_next);
    assign tabs_next = trace[W+2] ? unsigned'(-trace) : unsigned'(trace);

    always_comb
    begin
        is_max = 1'b1;
        is_min = 1'b1;
        for (int i = 0; i < dkwt_pkg::NUM_TAPS; i++)
        begin
            if (tap[i] > tap[dkwt_pkg::TAP_C]) is_max = 1'b0;
            if (tap[i] < tap[dkwt_pkg::TAP_C]) is_min = 1'b0;
        end
    end

    // zero center counts as a minimum candidate
    assign c_pos = !tap[dkwt_pkg::TAP_C][W-1] && (tap[dkwt_pkg::TAP_C] != '0);

    always_comb
    begin
        kind_next = dkwt_pkg::KIND_NONE;
        if (c_pos)
        begin
            if (is_max) kind_next = dkwt_pkg::KIND_MAX;
        end
        else
        begin
            if (is_min) kind_next = dkwt_pkg::KIND_MIN;
        end
    end

    assign c_ext         = (W + 1)'(tap[dkwt_pkg::TAP_C]);
    assign cmag          = c_ext[W] ? unsigned'(-c_ext) : unsigned'(c_ext);
    assign contrast_next = CMP_W'(cmag) > CMP_W'(thr_reg);

    logic signed [W+1:0] st1_dxx_reg, st1_dyy_reg, st1_dxy_reg;
    logic        [W+2:0] st1_tabs_reg;
    dkwt_pkg::kind_t     st1_kind_reg;
    logic                st1_contrast_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            st1_dxx_reg      <= dxx_next;
            st1_dyy_reg      <= dyy_next;
            st1_dxy_reg      <= dxy_next;
            st1_tabs_reg     <= tabs_next;
            st1_kind_reg     <= kind_next;
            st1_contrast_reg <= contrast_next;
        end
    end

    // -----------------------------------------------------------------
    // stage 2: products
    // -----------------------------------------------------------------
    logic signed [2*W+3:0] pab_next, pcc_next;
    logic        [2*W+5:0] tsq_next;

    assign pab_next = st1_dxx_reg * st1_dyy_reg;
    assign pcc_next = st1_dxy_reg * st1_dxy_reg;
    assign tsq_next = st1_tabs_reg * st1_tabs_reg;

    logic signed [2*W+3:0] st2_pab_reg, st2_pcc_reg;
    logic        [2*W+5:0] st2_tsq_reg;
    dkwt_pkg::kind_t       st2_kind_reg;
    logic                  st2_contrast_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            st2_pab_reg      <= pab_next;
            st2_pcc_reg      <= pcc_next;
            st2_tsq_reg      <= tsq_next;
            st2_kind_reg     <= st1_kind_reg;
            st2_contrast_reg <= st1_contrast_reg;
        end
    end

    // -----------------------------------------------------------------
    // stage 3: det = 16*dxx*dyy - (4dxy)^2, lhs/16 = trace^2*r/16
    // -----------------------------------------------------------------
    logic signed [DW-1:0]    det_next;
    logic        [2*W+13:0]  lhs_next;
    logic [dkwt_pkg::RATIO_WIDTH-1:0] st3_ratio;

    assign st3_ratio = ratio_reg;
    assign det_next = (DW'(st2_pab_reg) <<< 4) - DW'(st2_pcc_reg);
    assign lhs_next = st2_tsq_reg * st3_ratio;

    logic signed [DW-1:0]   st3_det_reg;
    logic        [2*W+13:0] st3_lhs_reg;
    dkwt_pkg::kind_t        st3_kind_reg;
    logic                   st3_contrast_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            st3_det_reg      <= det_next;
            st3_lhs_reg      <= lhs_next;
            st3_kind_reg     <= st2_kind_reg;
            st3_contrast_reg <= st2_contrast_reg;
        end
    end

    // -----------------------------------------------------------------
    // stage 4: det*(r+1)^2 as two partial products; only used when det > 0
    // -----------------------------------------------------------------
    logic          det_pos_next;
    logic [K-1:0]  det_lo, det_hi;
    logic [W+20:0] plo_next, phi_next;

    assign det_pos_next = !st3_det_reg[DW-1] && (st3_det_reg != '0);
    assign det_lo       = st3_det_reg[K-1:0];
    assign det_hi       = st3_det_reg[DW-2:K];
    assign plo_next     = det_lo * rsq_reg;
    assign phi_next     = det_hi * rsq_reg;

    logic [W+20:0]   st4_plo_reg, st4_phi_reg;
    logic [2*W+13:0] st4_lhs_reg;
    logic            st4_det_pos_reg;
    dkwt_pkg::kind_t st4_kind_reg;
    logic            st4_contrast_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            st4_plo_reg      <= plo_next;
            st4_phi_reg      <= phi_next;
            st4_lhs_reg      <= st3_lhs_reg;
            st4_det_pos_reg  <= det_pos_next;
            st4_kind_reg     <= st3_kind_reg;
            st4_contrast_reg <= st3_contrast_reg;
        end
    end

    // -----------------------------------------------------------------
    // stage 5: recombine, compare, output register
    // -----------------------------------------------------------------
    logic [RW-1:0] rhs, lhs_full;
    logic          curv_ok;
    logic          edge_next, key_next;

    assign rhs      = {st4_phi_reg, {K{1'b0}}} + RW'(st4_plo_reg);
    assign lhs_full = RW'({st4_lhs_reg, 4'b0000});
    assign curv_ok  = lhs_full < rhs;
    assign edge_next = !st4_det_pos_reg || !curv_ok;
    assign key_next  = st4_contrast_reg && (st4_kind_reg != dkwt_pkg::KIND_NONE) && !edge_next;

    logic            out_key_reg, out_contrast_reg, out_edge_reg;
    dkwt_pkg::kind_t out_kind_reg;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            out_key_reg      <= key_next;
            out_kind_reg     <= st4_kind_reg;
            out_contrast_reg <= st4_contrast_reg;
            out_edge_reg     <= edge_next;
        end
    end

    assign m_tdata = {3'b000, out_edge_reg, out_contrast_reg, out_kind_reg, out_key_reg};

    // -----------------------------------------------------------------
    // assertions
    // -----------------------------------------------------------------
    // an accepted window always lands in stage 1
    `DKWT_ASSERT_NEXT(a_accept_lands, clk, rst_n, s_tvalid && s_tready, v1_reg)
    // a determinant that is not positive always rejects the window
    `DKWT_ASSERT_NEXT(a_det_rejects, clk, rst_n,
        v4_reg && en5 && !st4_det_pos_reg, m_tvalid && out_edge_reg)
    // a keypoint implies all three tests passed
    `DKWT_ASSERT_SAME(a_key_consistent, clk, rst_n, m_tvalid && out_key_reg,
        out_contrast_reg && !out_edge_reg && (out_kind_reg != dkwt_pkg::KIND_NONE))
    // a held result keeps the stage behind it from overwriting it
    `DKWT_ASSERT_SAME(a_hold_blocks, clk, rst_n, m_tvalid && !m_tready && v4_reg, !en4)

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the DoG keypoint window test: random and directed
// 3x3 windows go in on the slave stream, and every verdict on the master
// stream is compared field by field against a local predictor.
// ---------------------------------------------------------------------------

// Holds the block's register copy and the verdicts still owed by the block.
class keypoint_scoreboard;

    typedef struct {
        logic               is_keypoint;
        dkwt_pkg::kind_t    kind;
        logic               contrast_ok;
        logic               edge_rejected;
    } verdict_t;

    verdict_t   expected_verdicts[$];
    int         errors = 0;
    longint     thr    = longint'(dkwt_pkg::THR_RESET);
    longint     ratio  = longint'(dkwt_pkg::RATIO_RESET);

    function void write_reg(logic [dkwt_pkg::CFG_INDEX_WIDTH-1:0] idx,
                            logic [dkwt_pkg::CFG_DATA_WIDTH-1:0] data);
        if (idx == dkwt_pkg::CFG_IDX_CONTRAST)
            thr = longint'(data[dkwt_pkg::THR_WIDTH-1:0]);
        else if (idx == dkwt_pkg::CFG_IDX_RATIO)
            ratio = longint'(data[dkwt_pkg::RATIO_WIDTH-1:0]);
    endfunction

    // exact integer form of the three tests; 64 bits cover every product
    function verdict_t judge(logic [143:0] win);
        verdict_t   v;
        longint     s[dkwt_pkg::NUM_TAPS];
        longint     ctr, mag, a, b, cx, det, tr, lhs, rhs;
        bit         is_max, is_min;
        for (int i = 0; i < dkwt_pkg::NUM_TAPS; i++)
            s[i] = longint'($signed(win[i*16 +: 16]));
        ctr = s[dkwt_pkg::TAP_C];
        mag = (ctr < 0) ? -ctr : ctr;
        v.contrast_ok = (mag > thr);

        is_max = 1'b1;
        is_min = 1'b1;
        for (int i = 0; i < dkwt_pkg::NUM_TAPS; i++)
        begin
            if (s[i] > ctr) is_max = 1'b0;
            if (s[i] < ctr) is_min = 1'b0;
        end
        // zero centre falls on the minimum side
        if (ctr > 0)
            v.kind = is_max ? dkwt_pkg::KIND_MAX : dkwt_pkg::KIND_NONE;
        else
            v.kind = is_min ? dkwt_pkg::KIND_MIN : dkwt_pkg::KIND_NONE;

        a   = 4 * (s[dkwt_pkg::TAP_MR] + s[dkwt_pkg::TAP_ML] - 2 * ctr);
        b   = 4 * (s[dkwt_pkg::TAP_BM] + s[dkwt_pkg::TAP_TM] - 2 * ctr);
        cx  = s[dkwt_pkg::TAP_BR] - s[dkwt_pkg::TAP_BL]
            - s[dkwt_pkg::TAP_TR] + s[dkwt_pkg::TAP_TL];
        det = a * b - cx * cx;
        if (det <= 0)
            v.edge_rejected = 1'b1;
        else
        begin
            tr  = (a + b < 0) ? -(a + b) : (a + b);
            lhs = tr * tr * ratio;
            rhs = det * (ratio + 1) * (ratio + 1);
            v.edge_rejected = !(lhs < rhs);
        end
        v.is_keypoint = v.contrast_ok && (v.kind != dkwt_pkg::KIND_NONE)
                        && !v.edge_rejected;
        return v;
    endfunction

    function void note_window(logic [143:0] win);
        expected_verdicts.insert(expected_verdicts.size(), judge(win));
    endfunction

    function void check_verdict(logic [dkwt_pkg::OUT_TDATA_WIDTH-1:0] tdata);
        verdict_t v;
        if (expected_verdicts.size() == 0)
        begin
            $error("verdict 0x%0h arrived with no window pending", tdata);
            errors++;
            return;
        end
        v = expected_verdicts.pop_front();
        if (tdata[0] !== v.is_keypoint)
        begin
            $error("is_keypoint: expected %0d, actual %0d", v.is_keypoint, tdata[0]);
            errors++;
        end
        if (tdata[2:1] !== v.kind)
        begin
            $error("extremum_kind: expected %0d, actual %0d", v.kind, tdata[2:1]);
            errors++;
        end
        if (tdata[3] !== v.contrast_ok)
        begin
            $error("contrast_ok: expected %0d, actual %0d", v.contrast_ok, tdata[3]);
            errors++;
        end
        if (tdata[4] !== v.edge_rejected)
        begin
            $error("edge_rejected: expected %0d, actual %0d", v.edge_rejected, tdata[4]);
            errors++;
        end
        if (tdata[7:5] !== 3'd0)
        begin
            $error("pad: expected 0, actual %0d", tdata[7:5]);
            errors++;
        end
    endfunction

    function int pending();
        return expected_verdicts.size();
    endfunction

endclass

module testbench;

    localparam int SW        = 16;
    localparam int TDATA_W   = ((9 * SW + 7) / 8) * 8;
    localparam int STALL_MAX = 2000;     // cycles with no transaction at all
    localparam int TAIL_CYC  = 20;       // pipeline is 5 deep; generous tail
    localparam int PHASE_LEN = 90;

    // indexes the block does not decode; writes to them must be dropped
    localparam logic [dkwt_pkg::CFG_INDEX_WIDTH-1:0] CFG_IDX_SPARE2 = 2'd2;
    localparam logic [dkwt_pkg::CFG_INDEX_WIDTH-1:0] CFG_IDX_SPARE3 = 2'd3;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   s_tvalid;
    logic                                   s_tready;
    logic [TDATA_W-1:0]                     s_tdata;
    logic                                   m_tvalid;
    logic                                   m_tready;
    logic [dkwt_pkg::OUT_TDATA_WIDTH-1:0]   m_tdata;
    logic                                   cfg_valid;
    logic                                   cfg_ready;
    logic [dkwt_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index;
    logic [dkwt_pkg::CFG_DATA_WIDTH-1:0]    cfg_data;

    keypoint_scoreboard board;
    bit                 calm = 1'b0;     // no idling on either side while set
    int                 quiet_cycles = 0;

    dog_keypoint_window_test #(
        .SAMPLE_WIDTH (SW)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Sink side: random back-pressure, tready low about 7 percent of the time.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (calm)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 7);
        end
    end

    // Monitor: all three channels are sampled at the edge, before any
    // driver updates land, so the scoreboard sees the transaction that
    // actually happened. Register writes only occur with nothing in flight.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                board.note_window(s_tdata[143:0]);
            if (m_tvalid && m_tready)
                board.check_verdict(m_tdata);
        end
    end

    // Watchdog: a run of cycles with no transaction on any channel is a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_MAX)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    function automatic int clamp16(int v);
        if (v > 32767)  return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // window in tap order, top_left in the lowest bits
    function automatic logic [TDATA_W-1:0] pack9(int tl, int tm, int tr, int ml, int ctr,
                                                 int mr, int bl, int bm, int br);
        logic [TDATA_W-1:0] w;
        int                 v[9];
        v = '{tl, tm, tr, ml, ctr, mr, bl, bm, br};
        w = '0;
        for (int i = 0; i < 9; i++)
            w[i*SW +: SW] = v[i][SW-1:0];
        return w;
    endfunction

    function automatic int extreme_sample();
        case ($urandom_range(7))
            0:       return -32768;
            1:       return -32767;
            2:       return -1;
            3:       return 0;
            4:       return 1;
            5:       return 32766;
            6:       return 32767;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // Mostly extremum-shaped windows (centre above or below all neighbours
    // by a random spread), so the edge test and keypoint flag see real use;
    // the rest is raw noise, extreme values and windows with one neighbour
    // breaking the extremum.
    function automatic logic [TDATA_W-1:0] random_window(int thr);
        int v[9];
        int pick, ctr, spread, dir, tap;
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            for (int i = 0; i < 9; i++)
                v[i] = int'($urandom_range(65535)) - 32768;
        end
        else if (pick < 30)
        begin
            for (int i = 0; i < 9; i++)
                v[i] = extreme_sample();
        end
        else
        begin
            if (pick < 85)
                ctr = $urandom_range(1) ? int'($urandom_range(65535)) - 32768
                                        : int'($urandom_range(1000)) - 500;
            else
            begin
                // centre right at the contrast threshold
                ctr = thr - 1 + int'($urandom_range(2));
                if ($urandom_range(1))
                    ctr = -ctr;
                ctr = clamp16(ctr);
            end
            case ($urandom_range(3))
                0:       spread = 3;
                1:       spread = 64;
                2:       spread = 2000;
                default: spread = 40000;
            endcase
            dir = (ctr > 0) ? -1 : 1;
            for (int i = 0; i < 9; i++)
                v[i] = clamp16(ctr + dir * int'($urandom_range(spread)));
            v[dkwt_pkg::TAP_C] = ctr;
            if (pick < 40)
            begin
                tap = $urandom_range(7);
                if (tap >= dkwt_pkg::TAP_C)
                    tap++;
                v[tap] = clamp16(ctr - dir * (1 + int'($urandom_range(spread))));
            end
        end
        return pack9(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
    endfunction

    // Holds the window until the transaction completes; idle cycles drop
    // tvalid first so gaps land anywhere in the stream.
    task automatic send_window(logic [TDATA_W-1:0] w);
        if (!calm)
            while ($urandom_range(99) < 7)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_cfg(logic [dkwt_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             logic [dkwt_pkg::CFG_DATA_WIDTH-1:0] data);
        if (!calm)
            while ($urandom_range(99) < 7)
            begin
                cfg_valid <= 1'b0;
                @(posedge clk);
            end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Stop the sender and wait until every owed verdict has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // New register setting between phases; spare writes check the decode.
    task automatic configure(int thr, int ratio, bit spare);
        logic [6:0] junk;
        junk = 7'($urandom_range(127));
        write_cfg(dkwt_pkg::CFG_IDX_CONTRAST, thr[dkwt_pkg::THR_WIDTH-1:0]);
        write_cfg(dkwt_pkg::CFG_IDX_RATIO, {junk, ratio[7:0]});
        if (spare)
        begin
            write_cfg(CFG_IDX_SPARE2, dkwt_pkg::CFG_DATA_WIDTH'($urandom_range(32767)));
            write_cfg(CFG_IDX_SPARE3, dkwt_pkg::CFG_DATA_WIDTH'($urandom_range(32767)));
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(int thr, int pause_at);
        for (int n = 0; n < PHASE_LEN; n++)
        begin
            if (n == pause_at)
                wait_drained();
            send_window(random_window(thr));
        end
        wait_drained();
    endtask

    initial
    begin
        int thr;
        // every input known from time zero
        board     = new;
        rst_n     = 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed windows under the reset setting.
        send_window(pack9(0, 0, 0, 0, 0, 0, 0, 0, 0));            // flat zero: min, no det
        send_window(pack9(0, 0, 0, 0, 32767, 0, 0, 0, 0));        // sharp positive peak
        send_window(pack9(32767, 32767, 32767, 32767, -32768,
                          32767, 32767, 32767, 32767));           // deepest pit
        send_window(pack9(32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767, 32767));           // flat top, tie max
        send_window(pack9(-32768, -32768, -32768, -32768, -32768,
                          -32768, -32768, -32768, -32768));       // flat bottom, tie min
        send_window(pack9(100, 200, 100, 100, 150, 100, 100, 100, 100)); // positive, not max
        send_window(pack9(-100, -100, -100, -300, -250,
                          -100, -100, -100, -100));               // negative, not min
        send_window(pack9(5, 5, 5, 5, 0, 5, 5, 5, 5));            // zero centre counts as min
        send_window(pack9(5, 5, 5, 5, 0, 5, -1, 5, 5));           // zero centre, one below
        send_window(pack9(0, 0, 0, 1000, 1000, 1000, 0, 0, 0));   // ridge: det zero
        send_window(pack9(3000, 0, -3000, 0, 1000, 0, -3000, 0, 3000)); // saddle twist
        send_window(pack9(0, 0, 0, 0, 218, 0, 0, 0, 0));          // at threshold
        send_window(pack9(0, 0, 0, 0, 219, 0, 0, 0, 0));          // just above
        send_window(pack9(0, 0, 0, 0, -218, 0, 0, 0, 0));
        send_window(pack9(0, 0, 0, 0, -219, 0, 0, 0, 0));
        send_window(pack9(900, 800, 900, 0, 1000, 0, 900, 800, 900)); // elongated peak
        send_window(pack9(990, 900, 990, 900, 1000,
                          900, 990, 900, 990));                   // round peak
        send_window(pack9(21845, 21845, 21845, 21845, 21845,
                          21845, 21845, 21845, 21845));           // 0x5555 pattern
        send_window(pack9(-21846, -21846, -21846, -21846, -21846,
                          -21846, -21846, -21846, -21846));       // 0xAAAA pattern
        send_window(pack9(-32768, 32767, -32768, 32767, 0,
                          32767, -32768, 32767, -32768));         // widest sums
        wait_drained();

        // Register sweeps, extremes first; the back-pressure-free stretch
        // runs in the second phase.
        configure(0, 1, 1'b1);
        random_phase(0, -1);

        calm = 1'b1;
        configure(32767, 255, 1'b0);
        random_phase(32767, -1);
        calm = 1'b0;

        // ratio zero reduces the edge test to det > 0
        thr = $urandom_range(500);
        configure(thr, 0, 1'b0);
        random_phase(thr, 45);

        configure(218, 10, 1'b1);
        random_phase(218, -1);

        thr = $urandom_range(32767);
        configure(thr, $urandom_range(1, 255), 1'b0);
        random_phase(thr, 30);

        configure(1, 2, 1'b0);
        random_phase(1, -1);

        repeat (TAIL_CYC) @(posedge clk);
        if (board.pending() != 0)
        begin
            $error("%0d verdicts never arrived", board.pending());
            board.errors++;
        end
        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
